// File: rtl/fsza_pkg.sv
// Shared types, codes and helpers of the fixed slot zone allocator.
`timescale 1ns / 1ps
package fsza_pkg;

  localparam int MAX_REGIONS_DEF = 8;
  localparam int MAX_SLOTS_DEF   = 256;

  localparam int ADDR_W     = 32;
  localparam int SLOT_W     = 17;
  localparam int HDR_W      = 9;
  localparam int OFS_W      = 5;
  localparam int ESLOT_W    = 18;
  localparam int OP_W       = 2;
  localparam int ST_W       = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int CHUNK      = 16;
  localparam int CHB        = 4;
  localparam int SLOT_ROUND = 15;

  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
  localparam logic [OP_W-1:0] OP_ADD    = 2'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd3;

  localparam logic [ST_W-1:0] ST_OK         = 3'd0;
  localparam logic [ST_W-1:0] ST_NO_SLOT    = 3'd1;
  localparam logic [ST_W-1:0] ST_UNKNOWN    = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL       = 3'd3;
  localparam logic [ST_W-1:0] ST_SMALL      = 3'd4;
  localparam logic [ST_W-1:0] ST_NONE_EMPTY = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 2'd2;

  localparam logic [SLOT_W-1:0] SLOT_SIZE_RST = 17'd16;
  localparam logic [HDR_W-1:0]  HEADER_RST    = 9'd32;
  localparam logic [OFS_W-1:0]  OFFSET_RST    = 5'd8;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] region_size;
  } in_word_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [ADDR_W-1:0] result_address;
    logic [ADDR_W-1:0] removed_size;
    logic              refill_request;
    logic              region_now_empty;
  } out_word_t;

  typedef struct packed {
    logic            load;
    logic            pos_clr;
    logic            pos_tot;
    logic            pos_inc;
    logic            alloc_scan;
    logic            alloc_mul;
    logic            alloc_addr;
    logic            free_mul;
    logic            div_free;
    logic            div_add;
    logic            free_upd;
    logic            add_wr;
    logic            rem_step;
    logic            set_st;
    logic            refill;
    logic            out_load;
    logic [ST_W-1:0] st;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            scan_end;
    logic            alloc_hit;
    logic            tbl_full;
    logic            too_small;
    logic            in_range;
    logic            div_done;
    logic            rem_hit;
    logic            pos_zero;
    logic            out_free;
  } dp_stat_t;

  // Slot size rounded up to 16 bytes; zero counts as 16.
  function automatic logic [ESLOT_W-1:0] eff_slot(input logic [SLOT_W-1:0] s);
    logic [ESLOT_W-1:0] t;
    t = ({1'b0, s} + ESLOT_W'(SLOT_ROUND)) & ~ESLOT_W'(SLOT_ROUND);
    if (t == '0) begin
      t = ESLOT_W'(CHUNK);
    end
    return t;
  endfunction

endpackage

// File: rtl/fsza_stream_if.sv
// Valid/ready channel that carries one word of a given payload type.
`timescale 1ns / 1ps
interface fsza_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/fsza_div.sv
// Restoring divider, one quotient bit per cycle, for slot index and slot count.
`timescale 1ns / 1ps
module fsza_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [fsza_pkg::ADDR_W-1:0]   dividend,
  input  logic [fsza_pkg::ESLOT_W-1:0]  divisor,
  output logic [fsza_pkg::ADDR_W-1:0]   quotient,
  output logic                          done
);
  import fsza_pkg::*;

  localparam int CW = $clog2(ADDR_W);

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [ADDR_W-1:0] q_r;
  logic [ESLOT_W:0]  rem_r;
  logic [ESLOT_W-1:0] dv_r;
  logic [ESLOT_W:0]  rem_sh;
  logic              ge;

  always_comb begin
    rem_sh = {rem_r[ESLOT_W-1:0], q_r[ADDR_W-1]};
    ge     = rem_sh >= {1'b0, dv_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(ADDR_W - 1);
        q_r    <= dividend;
        rem_r  <= '0;
        dv_r   <= divisor;
      end else if (busy_r) begin
        rem_r <= ge ? (rem_sh - {1'b0, dv_r}) : rem_sh;
        q_r   <= {q_r[ADDR_W-2:0], ge};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign quotient = q_r;
  assign done     = done_r;
endmodule

// File: rtl/fsza_ctrl.sv
// Sequencer that steps the allocator datapath through each operation.
`timescale 1ns / 1ps
module fsza_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fsza_pkg::dp_stat_t stat,
  output fsza_pkg::dp_cmd_t  cmd
);
  import fsza_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_ASCAN = 4'd2;
  localparam logic [3:0] S_AMUL  = 4'd3;
  localparam logic [3:0] S_AADDR = 4'd4;
  localparam logic [3:0] S_FMUL  = 4'd5;
  localparam logic [3:0] S_FCMP  = 4'd6;
  localparam logic [3:0] S_FDIV  = 4'd7;
  localparam logic [3:0] S_FUPD  = 4'd8;
  localparam logic [3:0] S_ADIV  = 4'd9;
  localparam logic [3:0] S_AWR   = 4'd10;
  localparam logic [3:0] S_RSCAN = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.op)
          OP_ALLOC: begin
            cmd.pos_clr = 1'b1;
            state_nxt   = S_ASCAN;
          end
          OP_FREE: begin
            cmd.pos_clr = 1'b1;
            cmd.set_st  = 1'b1;
            cmd.st      = ST_UNKNOWN;
            state_nxt   = S_FMUL;
          end
          OP_ADD: begin
            if (stat.tbl_full) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_FULL;
              state_nxt  = S_DONE;
            end else if (stat.too_small) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_SMALL;
              state_nxt  = S_DONE;
            end else begin
              cmd.div_add = 1'b1;
              state_nxt   = S_ADIV;
            end
          end
          default: begin
            cmd.pos_tot = 1'b1;
            state_nxt   = S_RSCAN;
          end
        endcase
      end
      S_ASCAN: begin
        if (stat.scan_end) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_NO_SLOT;
          cmd.refill = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          cmd.alloc_scan = 1'b1;
          if (stat.alloc_hit) begin
            state_nxt = S_AMUL;
          end
        end
      end
      S_AMUL: begin
        cmd.alloc_mul = 1'b1;
        state_nxt     = S_AADDR;
      end
      S_AADDR: begin
        cmd.alloc_addr = 1'b1;
        state_nxt      = S_DONE;
      end
      S_FMUL: begin
        if (stat.scan_end) begin
          state_nxt = S_DONE;
        end else begin
          cmd.free_mul = 1'b1;
          state_nxt    = S_FCMP;
        end
      end
      S_FCMP: begin
        if (stat.in_range) begin
          cmd.div_free = 1'b1;
          state_nxt    = S_FDIV;
        end else begin
          cmd.pos_inc = 1'b1;
          state_nxt   = S_FMUL;
        end
      end
      S_FDIV: begin
        if (stat.div_done) begin
          state_nxt = S_FUPD;
        end
      end
      S_FUPD: begin
        cmd.free_upd = 1'b1;
        state_nxt    = S_DONE;
      end
      S_ADIV: begin
        if (stat.div_done) begin
          state_nxt = S_AWR;
        end
      end
      S_AWR: begin
        cmd.add_wr = 1'b1;
        state_nxt  = S_DONE;
      end
      S_RSCAN: begin
        if (stat.pos_zero) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_NONE_EMPTY;
          state_nxt  = S_DONE;
        end else begin
          cmd.rem_step = 1'b1;
          if (stat.rem_hit) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

// File: rtl/fsza_dp.sv
// Region table, slot maps, address arithmetic and result register.
`timescale 1ns / 1ps
module fsza_dp #(
  parameter int MAX_REGIONS = fsza_pkg::MAX_REGIONS_DEF,
  parameter int MAX_SLOTS   = fsza_pkg::MAX_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fsza_pkg::in_word_t               in_data,
  output fsza_pkg::out_word_t              out_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  input  logic                             cfg_we,
  input  logic [fsza_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fsza_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  fsza_pkg::dp_cmd_t                cmd,
  output fsza_pkg::dp_stat_t               stat
);
  import fsza_pkg::*;

  localparam int IDXW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNTW = $clog2(MAX_REGIONS + 1);
  localparam int SLW  = $clog2(MAX_SLOTS + 1);
  localparam int NCH  = (MAX_SLOTS + CHUNK - 1) / CHUNK;
  localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int SIW  = CHW + CHB;
  localparam int ROWW = NCH * CHUNK;
  localparam int IXW  = (SIW > SLW) ? SIW : SLW;
  localparam int LIMW = SLW + ESLOT_W;
  localparam int CMPW = (LIMW > ADDR_W) ? LIMW : ADDR_W;

  logic [SLOT_W-1:0] slot_size_r;
  logic [HDR_W-1:0]  hdr_r;
  logic [OFS_W-1:0]  ofs_r;

  logic [ADDR_W-1:0] base_r  [MAX_REGIONS];
  logic [ADDR_W-1:0] bytes_r [MAX_REGIONS];
  logic [SLW-1:0]    scnt_r  [MAX_REGIONS];
  logic [SLW-1:0]    used_r  [MAX_REGIONS];
  logic [ROWW-1:0]   busy_r  [MAX_REGIONS];
  logic [IDXW-1:0]   order_r [MAX_REGIONS];
  logic [IDXW-1:0]   order_nxt [MAX_REGIONS];
  logic [CNTW-1:0]   total_r;

  logic [OP_W-1:0]   op_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] size_r;
  logic [CNTW-1:0]   pos_r;
  logic [CHW-1:0]    ch_r;
  logic [SIW-1:0]    sidx_r;
  logic [ADDR_W-1:0] prod_r;
  logic [ADDR_W-1:0] off_r;
  logic [LIMW-1:0]   lim_r;

  logic [ST_W-1:0]   res_st_r;
  logic [ADDR_W-1:0] res_addr_r;
  logic [ADDR_W-1:0] res_rsz_r;
  logic              res_refill_r;
  logic              res_empty_r;
  out_word_t         out_r;
  logic              out_valid_r;

  logic [ESLOT_W-1:0]   eslot;
  logic [IDXW-1:0]      cur;
  logic [CNTW-1:0]      pm1;
  logic [IDXW-1:0]      rr;
  logic [IDXW-1:0]      newr;
  logic [CHUNK-1:0]     chunk_bits;
  logic [CHUNK-1:0]     free_vec;
  logic [CHB-1:0]       first;
  logic                 hit;
  logic [IXW:0]         nstart;
  logic                 chunk_last;
  logic [SIW+ESLOT_W-1:0] pmul;
  logic [ADDR_W-1:0]    div_q;
  logic                 div_done;
  logic [ADDR_W-1:0]    div_a;
  logic [SIW-1:0]       fidx;
  logic [SLW-1:0]       used_dec;
  logic [SLW-1:0]       nsat;
  logic                 mv_en;
  logic [IDXW-1:0]      mv_p;
  logic [IDXW-1:0]      mv_last;

  fsza_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_free | cmd.div_add),
    .dividend (div_a),
    .divisor  (eslot),
    .quotient (div_q),
    .done     (div_done)
  );

  always_comb begin
    eslot      = eff_slot(slot_size_r);
    cur        = order_r[pos_r[IDXW-1:0]];
    pm1        = pos_r - 1'b1;
    rr         = order_r[pm1[IDXW-1:0]];
    newr       = order_r[total_r[IDXW-1:0]];
    chunk_bits = busy_r[cur][ch_r*CHUNK +: CHUNK];
    for (int k = 0; k < CHUNK; k++) begin
      free_vec[k] = ~chunk_bits[k] &&
                    (IXW'({ch_r, CHB'(k)}) < IXW'(scnt_r[cur]));
    end
    first = '0;
    for (int k = CHUNK - 1; k >= 0; k--) begin
      if (free_vec[k]) begin
        first = CHB'(k);
      end
    end
    hit        = |free_vec;
    nstart     = ((IXW+1)'(ch_r) + (IXW+1)'(1)) << CHB;
    chunk_last = nstart >= (IXW+1)'(scnt_r[cur]);
    pmul       = sidx_r * eslot;
    div_a      = cmd.div_add ? (size_r - ADDR_W'(hdr_r)) : off_r;
    fidx       = div_q[SIW-1:0];
    used_dec   = (used_r[cur] != '0) ? (used_r[cur] - 1'b1) : '0;
    nsat       = (div_q > ADDR_W'(MAX_SLOTS)) ? SLW'(MAX_SLOTS) : div_q[SLW-1:0];

    mv_en   = 1'b0;
    mv_p    = pos_r[IDXW-1:0];
    mv_last = IDXW'(total_r - 1'b1);
    if (cmd.free_upd && busy_r[cur][fidx] && used_dec == '0) begin
      mv_en = 1'b1;
    end
    if (cmd.rem_step && used_r[rr] == '0) begin
      mv_en   = 1'b1;
      mv_p    = pm1[IDXW-1:0];
      mv_last = IDXW'(MAX_REGIONS - 1);
    end
    for (int q = 0; q < MAX_REGIONS; q++) begin
      if (IDXW'(q) >= mv_p && IDXW'(q) < mv_last) begin
        order_nxt[q] = order_r[(q + 1) % MAX_REGIONS];
      end else if (IDXW'(q) == mv_last) begin
        order_nxt[q] = order_r[mv_p];
      end else begin
        order_nxt[q] = order_r[q];
      end
    end

    stat.op        = op_r;
    stat.scan_end  = pos_r >= total_r;
    stat.alloc_hit = hit;
    stat.tbl_full  = total_r == CNTW'(MAX_REGIONS);
    stat.too_small = size_r < ADDR_W'(hdr_r);
    stat.in_range  = CMPW'(off_r) < CMPW'(lim_r);
    stat.div_done  = div_done;
    stat.rem_hit   = used_r[rr] == '0;
    stat.pos_zero  = pos_r == '0;
    stat.out_free  = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_size_r <= SLOT_SIZE_RST;
      hdr_r       <= HEADER_RST;
      ofs_r       <= OFFSET_RST;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      for (int q = 0; q < MAX_REGIONS; q++) begin
        order_r[q] <= IDXW'(q);
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SLOT_SIZE: slot_size_r <= cfg_data[SLOT_W-1:0];
          CFG_HEADER:    hdr_r <= cfg_data[HDR_W-1:0];
          CFG_OFFSET:    ofs_r <= cfg_data[OFS_W-1:0];
          default: ;
        endcase
      end
      if (mv_en) begin
        order_r <= order_nxt;
      end
      if (cmd.add_wr) begin
        total_r <= total_r + 1'b1;
      end
      if (cmd.rem_step && used_r[rr] == '0) begin
        total_r <= total_r - 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r         <= in_data.op;
      addr_r       <= (in_data.op == OP_FREE) ? (in_data.address - ADDR_W'(ofs_r))
                                               : in_data.address;
      size_r       <= in_data.region_size;
      res_st_r     <= ST_OK;
      res_addr_r   <= '0;
      res_rsz_r    <= '0;
      res_refill_r <= 1'b0;
      res_empty_r  <= 1'b0;
    end
    if (cmd.set_st) begin
      res_st_r <= cmd.st;
    end
    if (cmd.refill) begin
      res_refill_r <= 1'b1;
    end
    if (cmd.pos_clr) begin
      pos_r <= '0;
      ch_r  <= '0;
    end
    if (cmd.pos_tot) begin
      pos_r <= total_r;
    end
    if (cmd.pos_inc) begin
      pos_r <= pos_r + 1'b1;
    end
    if (cmd.alloc_scan) begin
      if (hit) begin
        busy_r[cur][{ch_r, first}] <= 1'b1;
        used_r[cur] <= used_r[cur] + 1'b1;
        sidx_r      <= {ch_r, first};
      end else if (chunk_last) begin
        pos_r <= pos_r + 1'b1;
        ch_r  <= '0;
      end else begin
        ch_r <= ch_r + 1'b1;
      end
    end
    if (cmd.alloc_mul) begin
      prod_r <= ADDR_W'(pmul);
    end
    if (cmd.alloc_addr) begin
      res_addr_r <= base_r[cur] + ADDR_W'(hdr_r) + prod_r + ADDR_W'(ofs_r);
    end
    if (cmd.free_mul) begin
      off_r <= addr_r - base_r[cur] - ADDR_W'(hdr_r);
      lim_r <= scnt_r[cur] * eslot;
    end
    if (cmd.free_upd && busy_r[cur][fidx]) begin
      busy_r[cur][fidx] <= 1'b0;
      used_r[cur]       <= used_dec;
      res_st_r          <= ST_OK;
      if (used_dec == '0) begin
        res_empty_r <= 1'b1;
      end
    end
    if (cmd.add_wr) begin
      base_r[newr]  <= addr_r;
      bytes_r[newr] <= size_r;
      scnt_r[newr]  <= nsat;
      used_r[newr]  <= '0;
      busy_r[newr]  <= '0;
    end
    if (cmd.rem_step) begin
      if (used_r[rr] == '0) begin
        res_addr_r <= base_r[rr];
        res_rsz_r  <= bytes_r[rr];
      end else begin
        pos_r <= pm1;
      end
    end
    if (cmd.out_load) begin
      out_r.status           <= res_st_r;
      out_r.result_address   <= res_addr_r;
      out_r.removed_size     <= res_rsz_r;
      out_r.refill_request   <= res_refill_r;
      out_r.region_now_empty <= res_empty_r;
    end
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;
endmodule

// File: rtl/fixed_slot_zone_allocator_top.sv
// Top level of the fixed slot zone allocator.
//
// Requests arrive as words on in_ch (op, address, region_size) and each
// request yields exactly one result word on out_ch. The block works on one
// request at a time: in_ch.ready is high only while it waits for a request.
// Alloc scans the slot map one 16-slot group at a time, region by region;
// that scan sets how long it takes. Free tests each region in turn and
// then runs the 32-step slot index divider. Add region runs the same
// divider. Remove tests regions from the newest back until it finds an
// unused one, and reports none empty when no region is unused.
// The result sits in an output register; a new request is taken while it
// waits, and the next result is held back until the receiver takes it.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while the block is idle; the block does not enforce it.
// After reset the region table is empty, slot size is 16, header size 32 and
// object offset 8; no clearing pass is needed.
`timescale 1ns / 1ps
module fixed_slot_zone_allocator_top #(
  parameter int MAX_REGIONS = fsza_pkg::MAX_REGIONS_DEF,
  parameter int MAX_SLOTS   = fsza_pkg::MAX_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  fsza_stream_if.sink                      in_ch,
  fsza_stream_if.source                    out_ch,
  input  logic                             cfg_we,
  input  logic [fsza_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fsza_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fsza_pkg::*;

  dp_cmd_t   cmd;
  dp_stat_t  stat;
  in_word_t  in_word;
  out_word_t out_word;
  logic      in_rdy;
  logic      out_vld;

  assign in_word      = in_ch.data;
  assign in_ch.ready  = in_rdy;
  assign out_ch.valid = out_vld;
  assign out_ch.data  = out_word;

  fsza_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_rdy),
    .stat     (stat),
    .cmd      (cmd)
  );

  fsza_dp #(
    .MAX_REGIONS (MAX_REGIONS),
    .MAX_SLOTS   (MAX_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_word),
    .out_data  (out_word),
    .out_valid (out_vld),
    .out_ready (out_ch.ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );
endmodule
